// File: rtl/core/spr_pkg.sv
// Shared types and constants of the stream pattern replacer.
package spr_pkg;

  localparam int MAX_PATTERN_DEFAULT = 16;
  localparam int SLOT_BYTES          = 16;
  localparam int BYTE_W              = 8;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_INDEX_W         = 3;
  localparam int LEN_W               = 5;
  localparam int REP_IDX_W           = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LOW    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_HIGH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd5;

  typedef logic [SLOT_BYTES-1:0][BYTE_W-1:0] slot_t;

  typedef struct packed {
    logic load;         // latch config if nothing held, append the input byte
    logic clear;        // drop held bytes after a match, rewind replacement index
    logic rel;          // release the oldest held byte to the output
    logic emit_rep;     // send the next replacement byte
    logic emit_marker;  // send the end marker
    logic out_last;     // mark the result sent this cycle as final
  } cmd_t;

  typedef struct packed {
    logic match;
    logic need_release;
    logic count_one;
    logic rep_len_zero;
    logic rep_last;
    logic can_emit;
  } status_t;

endpackage

// File: rtl/core/stream_pattern_replacer_core.sv
// Top level of the streaming pattern replacer: config, controller and datapath.
// Sequence: an input byte is taken in idle and checked in the following cycle; each
//   result leaves through the output register in the cycle after it is formed.
// Throughput: an input byte causes R results (0 to 16), all formed before the next
//   byte; the single output register passes one result per cycle unless stalled.
// Reset (rst, synchronous, active high): nothing held, config at reset values.
module stream_pattern_replacer_core #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] in_byte
  input  logic                              s_axis_tlast,   // in_last
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] out_byte
  output logic                              m_axis_tuser,   // [0] has_byte
  output logic                              m_axis_tlast,   // out_last
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [spr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  spr_pkg::cmd_t                  cmd;
  spr_pkg::status_t               status;
  spr_pkg::slot_t                 cfg_pat, cfg_rep;
  logic [spr_pkg::LEN_W-1:0]      cfg_plen, cfg_rlen;

  // Register writes land here; the datapath copies them at the start of a
  // byte that finds nothing held, so a partial match finishes on one pattern.
  spr_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_pat   (cfg_pat),
    .cfg_plen  (cfg_plen),
    .cfg_rep   (cfg_rep),
    .cfg_rlen  (cfg_rlen)
  );

  // Accept a byte only in idle; the output register can still hold the
  // previous result while the next transfer comes in.
  spr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  spr_datapath #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_axis_tdata),
    .cfg_pat   (cfg_pat),
    .cfg_plen  (cfg_plen),
    .cfg_rep   (cfg_rep),
    .cfg_rlen  (cfg_rlen),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .has_byte  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: rtl/core/spr_cfg.sv
// Configuration register file with length saturation.
module spr_cfg #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [spr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_data,
  output spr_pkg::slot_t                      cfg_pat,
  output logic [spr_pkg::LEN_W-1:0]           cfg_plen,
  output spr_pkg::slot_t                      cfg_rep,
  output logic [spr_pkg::LEN_W-1:0]           cfg_rlen
);

  localparam int CAP = (MAX_PATTERN < spr_pkg::SLOT_BYTES) ? MAX_PATTERN
                                                           : spr_pkg::SLOT_BYTES;

  logic [spr_pkg::CFG_DATA_W-1:0] pat_low, pat_high, rep_low, rep_high;
  logic [spr_pkg::LEN_W-1:0]      pat_len, rep_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= spr_pkg::LEN_W'(1);
      rep_low  <= '0;
      rep_high <= '0;
      rep_len  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spr_pkg::REG_PATTERN_LOW:        pat_low  <= cfg_data;
        spr_pkg::REG_PATTERN_HIGH:       pat_high <= cfg_data;
        spr_pkg::REG_PATTERN_LENGTH:     pat_len  <= cfg_data[spr_pkg::LEN_W-1:0];
        spr_pkg::REG_REPLACEMENT_LOW:    rep_low  <= cfg_data;
        spr_pkg::REG_REPLACEMENT_HIGH:   rep_high <= cfg_data;
        spr_pkg::REG_REPLACEMENT_LENGTH: rep_len  <= cfg_data[spr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_pat = {pat_high, pat_low};
  assign cfg_rep = {rep_high, rep_low};

  // Zero counts as one; clamp to the held-byte capacity.
  always_comb begin
    if (pat_len == '0) begin
      cfg_plen = spr_pkg::LEN_W'(1);
    end else if (pat_len > spr_pkg::LEN_W'(CAP)) begin
      cfg_plen = spr_pkg::LEN_W'(CAP);
    end else begin
      cfg_plen = pat_len;
    end
  end

  always_comb begin
    if (rep_len > spr_pkg::LEN_W'(spr_pkg::SLOT_BYTES)) begin
      cfg_rlen = spr_pkg::LEN_W'(spr_pkg::SLOT_BYTES);
    end else begin
      cfg_rlen = rep_len;
    end
  end

endmodule

// File: rtl/core/spr_datapath.sv
// Held-byte shift register, active config copy, prefix compare and output register.
module spr_datapath #(
  parameter int MAX_PATTERN = spr_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spr_pkg::cmd_t                    cmd,
  output spr_pkg::status_t                 status,
  input  logic [spr_pkg::BYTE_W-1:0]       in_byte,
  input  spr_pkg::slot_t                   cfg_pat,
  input  logic [spr_pkg::LEN_W-1:0]        cfg_plen,
  input  spr_pkg::slot_t                   cfg_rep,
  input  logic [spr_pkg::LEN_W-1:0]        cfg_rlen,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             has_byte,
  output logic                             out_last
);

  localparam int CAP = (MAX_PATTERN < spr_pkg::SLOT_BYTES) ? MAX_PATTERN
                                                           : spr_pkg::SLOT_BYTES;
  localparam int CW  = $clog2(CAP + 1);
  localparam int IW  = $clog2(CAP);

  logic [CAP-1:0][spr_pkg::BYTE_W-1:0] held;
  logic [CW-1:0]                       count;
  spr_pkg::slot_t                      act_pat, act_rep;
  logic [spr_pkg::LEN_W-1:0]           act_plen, act_rlen;
  logic [spr_pkg::REP_IDX_W-1:0]       rep_idx;
  logic [CW-1:0]                       plen_c;
  logic                                prefix;
  logic                                emit;

  assign plen_c = CW'(act_plen);
  assign emit   = cmd.rel | cmd.emit_rep | cmd.emit_marker;

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < CAP; i++) begin
      if ((CW'(i) < count) && (held[i] != act_pat[i])) begin
        prefix = 1'b0;
      end
    end
  end

  assign status.match        = (count == plen_c) && prefix;
  assign status.need_release = (count >= plen_c) || !prefix;
  assign status.count_one    = (count == CW'(1));
  assign status.rep_len_zero = (act_rlen == '0);
  assign status.rep_last     = ({1'b0, rep_idx} + spr_pkg::LEN_W'(1)) == act_rlen;
  assign status.can_emit     = !out_valid || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rep_idx   <= '0;
      out_valid <= 1'b0;
      act_pat   <= '0;
      act_rep   <= '0;
      act_plen  <= spr_pkg::LEN_W'(1);
      act_rlen  <= '0;
    end else begin
      if (cmd.load) begin
        if (count == '0) begin
          act_pat  <= cfg_pat;
          act_rep  <= cfg_rep;
          act_plen <= cfg_plen;
          act_rlen <= cfg_rlen;
        end
        count <= count + CW'(1);
      end else if (cmd.clear) begin
        count   <= '0;
        rep_idx <= '0;
      end else if (cmd.rel) begin
        count <= count - CW'(1);
      end
      if (cmd.emit_rep) begin
        rep_idx <= rep_idx + spr_pkg::REP_IDX_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held[count[IW-1:0]] <= in_byte;
    end else if (cmd.rel) begin
      for (int i = 0; i < CAP - 1; i++) begin
        held[i] <= held[i + 1];
      end
    end
    if (emit) begin
      out_last <= cmd.out_last;
      if (cmd.rel) begin
        out_byte <= held[0];
        has_byte <= 1'b1;
      end else if (cmd.emit_rep) begin
        out_byte <= act_rep[rep_idx];
        has_byte <= 1'b1;
      end else begin
        out_byte <= '0;
        has_byte <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/spr_ctrl.sv
// Controller state machine: sequences append, match, replacement, release, flush and end marker.
module spr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  spr_pkg::status_t  status,
  output spr_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REP,
    S_FLUSH,
    S_MARK
  } state_t;

  state_t state, state_next;
  logic   last_flag;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.match) begin
          cmd.clear = 1'b1;
          if (!status.rep_len_zero) begin
            state_next = S_REP;
          end else if (last_flag) begin
            state_next = S_MARK;
          end else begin
            state_next = S_IDLE;
          end
        end else if (last_flag) begin
          state_next = S_FLUSH;
        end else if (!status.need_release) begin
          state_next = S_IDLE;
        end else if (status.can_emit) begin
          cmd.rel = 1'b1;
        end
      end
      S_REP: begin
        if (status.can_emit) begin
          cmd.emit_rep = 1'b1;
          cmd.out_last = last_flag && status.rep_last;
          if (status.rep_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (status.can_emit) begin
          cmd.rel      = 1'b1;
          cmd.out_last = status.count_one;
          if (status.count_one) begin
            state_next = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (status.can_emit) begin
          cmd.emit_marker = 1'b1;
          cmd.out_last    = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        last_flag <= in_last;
      end
    end
  end

endmodule
